FILE: hw/rtl/mau_pkg.sv
// mau_pkg: shared constants and types of the modular arithmetic unit
// no dependencies; used by mau_reduce and modular_arithmetic_unit
package mau_pkg;

   localparam int DATA_WIDTH_DEF = 63;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

endpackage

FILE: hw/rtl/mau_reduce.sv
// mau_reduce: bit-serial reduction of one operand modulo m, msb first
// depends on mau_pkg for the default width
module mau_reduce #(
   parameter int DATA_WIDTH = mau_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [DATA_WIDTH-1:0] modulus,
   output logic                  busy,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);

   logic [W-1:0]  val_ff, val_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    rem_next;

   always_comb begin
      val_in   = val_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      rem_next = {rem_ff, val_ff[W-1]};
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one bit, subtract m once when it fits
         if (rem_next >= {1'b0, modulus}) begin
            rem_next = rem_next - {1'b0, modulus};
         end
         rem_in = rem_next[W-1:0];
         val_in = {val_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/modular_arithmetic_unit.sv
// modular_arithmetic_unit: add, subtract, multiply, divide modulo a configured modulus
// operation: both operands are reduced modulo m first, then add and subtract finish in S_OP,
// multiply double-and-adds the right operand; divide runs euclid steps, then a final multiply
// throughput: one beat at a time; req_stall stays high until the result is in the output register
// the shared double-and-add unit sets the rate: each operand bit passes S_DBL, then S_ADD
// reset: synchronous, active high; modulus resets to 1, no result pending
// depends on mau_pkg and mau_reduce
module modular_arithmetic_unit #(
   parameter int DATA_WIDTH = mau_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [DATA_WIDTH-1:0] req_left_operand,
   input  logic [DATA_WIDTH-1:0] req_right_operand,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_result_value,
   output logic                  rsp_undefined_flag,
   // modulus register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DATA_WIDTH-1:0] csr_modulus
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RED  = 7'b0000010,
      S_OP   = 7'b0000100,
      S_DBL  = 7'b0001000,
      S_ADD  = 7'b0010000,
      S_EUC  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                            input logic [W-1:0] y,
                                            input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x,
                                            input logic [W-1:0] y,
                                            input logic [W-1:0] m);
      logic [W:0] s;
      if (x >= y) begin
         s = {1'b0, x} - {1'b0, y};
      end else begin
         s = {1'b0, x} + {1'b0, m} - {1'b0, y};
      end
      return s[W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [W-1:0]     csr_mod_ff;
   logic [W-1:0]     m_ff, m_in;
   mau_pkg::mode_type mode_ff, mode_in;
   logic [W-1:0]     a_ff, a_in;
   // shared double-and-add unit
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     addend_ff, addend_in;
   logic [W-1:0]     bits_ff, bits_in;
   logic             qbit_ff, qbit_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             is_div_ff, is_div_in;
   // euclid state
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     r1_ff, r1_in;
   logic [W-1:0]     t0_ff, t0_in;
   logic [W-1:0]     t1_ff, t1_in;
   // finished result and output register
   logic [W-1:0]     res_ff, res_in;
   logic             undef_ff, undef_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]     rsp_res_ff, rsp_res_in;
   logic             rsp_undef_ff, rsp_undef_in;

   logic             req_accept;
   logic             red_a_busy, red_b_busy;
   logic [W-1:0]     red_a, red_b;
   logic [W:0]       rem_next;
   logic [W-1:0]     t2;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   // operand reducers run side by side
   mau_reduce #(.DATA_WIDTH(W)) u_red_a (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .value     (req_left_operand),
      .modulus   (m_ff),
      .busy      (red_a_busy),
      .remainder (red_a)
   );

   mau_reduce #(.DATA_WIDTH(W)) u_red_b (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .value     (req_right_operand),
      .modulus   (m_ff),
      .busy      (red_b_busy),
      .remainder (red_b)
   );

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      addend_in    = addend_ff;
      bits_in      = bits_ff;
      qbit_in      = qbit_ff;
      cnt_in       = cnt_ff;
      is_div_in    = is_div_ff;
      rem_in       = rem_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      res_in       = res_ff;
      undef_in     = undef_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_undef_in = rsp_undef_ff;
      rem_next     = {rem_ff, bits_ff[W-1]};
      t2           = sub_mod(t0_ff, acc_ff, m_ff);

      // output register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               // a zero modulus acts as one
               m_in     = (csr_mod_ff == '0) ? W'(1) : csr_mod_ff;
               mode_in  = mau_pkg::mode_type'(req_mode);
               state_in = S_RED;
            end
         end
         S_RED: begin
            if (!red_a_busy && !red_b_busy) begin
               a_in     = red_a;
               state_in = S_OP;
            end
         end
         S_OP: begin
            undef_in = 1'b0;
            acc_in   = '0;
            cnt_in   = '0;
            rem_in   = '0;
            unique case (mode_ff)
               mau_pkg::MODE_ADD: begin
                  res_in   = add_mod(a_ff, red_b, m_ff);
                  state_in = S_DONE;
               end
               mau_pkg::MODE_SUB: begin
                  res_in   = sub_mod(a_ff, red_b, m_ff);
                  state_in = S_DONE;
               end
               mau_pkg::MODE_MUL: begin
                  addend_in = a_ff;
                  bits_in   = red_b;
                  is_div_in = 1'b0;
                  state_in  = S_DBL;
               end
               mau_pkg::MODE_DIV: begin
                  if (red_b == '0) begin
                     res_in   = '0;
                     undef_in = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     // first euclid step: divide m by b
                     r1_in     = red_b;
                     t0_in     = '0;
                     t1_in     = (m_ff == W'(1)) ? '0 : W'(1);
                     addend_in = (m_ff == W'(1)) ? '0 : W'(1);
                     bits_in   = m_ff;
                     is_div_in = 1'b1;
                     state_in  = S_DBL;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DBL: begin
            // double the accumulator; in euclid also one restoring division bit
            acc_in  = add_mod(acc_ff, acc_ff, m_ff);
            bits_in = {bits_ff[W-2:0], 1'b0};
            if (is_div_ff) begin
               if (rem_next >= {1'b0, r1_ff}) begin
                  qbit_in  = 1'b1;
                  rem_next = rem_next - {1'b0, r1_ff};
               end else begin
                  qbit_in = 1'b0;
               end
               rem_in = rem_next[W-1:0];
            end else begin
               qbit_in = bits_ff[W-1];
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            if (qbit_ff) begin
               acc_in = add_mod(acc_ff, addend_ff, m_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               if (is_div_ff) begin
                  state_in = S_EUC;
               end else begin
                  res_in   = acc_in;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DBL;
            end
         end
         S_EUC: begin
            // remainder and coefficient rotate down one place
            acc_in = '0;
            cnt_in = '0;
            rem_in = '0;
            r1_in  = rem_ff;
            t0_in  = t1_ff;
            t1_in  = t2;
            if (rem_ff == '0) begin
               if (r1_ff == W'(1)) begin
                  // inverse found: multiply the left operand by it
                  addend_in = a_ff;
                  bits_in   = t1_ff;
                  is_div_in = 1'b0;
                  state_in  = S_DBL;
               end else begin
                  res_in   = '0;
                  undef_in = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               addend_in = t2;
               bits_in   = r1_ff;
               state_in  = S_DBL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_undef_in = undef_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_mod_ff   <= W'(1);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            csr_mod_ff <= csr_modulus;
         end
      end
      m_ff         <= m_in;
      mode_ff      <= mode_in;
      a_ff         <= a_in;
      acc_ff       <= acc_in;
      addend_ff    <= addend_in;
      bits_ff      <= bits_in;
      qbit_ff      <= qbit_in;
      is_div_ff    <= is_div_in;
      rem_ff       <= rem_in;
      r1_ff        <= r1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      res_ff       <= res_in;
      undef_ff     <= undef_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_undef_ff <= rsp_undef_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_res_ff;
   assign rsp_undefined_flag = rsp_undef_ff;

endmodule
